// ----- rtl/bscfe_pkg.sv -----
// Shared types and codes for the bit-stuffed CRC frame encoder.
// Holds the command codes and the beat formats passed between the modules.
// No dependencies.
package bscfe_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_CRC   = 2'd2;
  localparam logic [1:0] OP_END   = 2'd3;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);
  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = $clog2(RES_DEPTH);

  // One decoded command. For append CRC, byte0 and byte1 are the low and
  // high CRC bytes captured at accept time.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       mark;
    logic       last;
  } res_t;

endpackage

// ----- rtl/bscfe_front.sv -----
// Front end: accepts commands, keeps the running CRC and queues decoded
// commands for the symbol engine.
// Depends on bscfe_pkg.
module bscfe_front import bscfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       full_o,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  localparam logic [15:0] CRC_POLY = 16'h8408;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {8'h00, d};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [15:0]     crc_q, crc_d;
  logic [15:0]     crc_lo;
  cmd_t            entry_d;
  cmd_t            entries_q [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_AW:0]   cnt_q, cnt_d;
  logic            accept;

  assign full_o      = (cnt_q == (CMD_AW+1)'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = entries_q[rd_ptr_q];
  assign accept      = push_i && !full_o;

  always_comb begin
    crc_lo        = crc16_byte(crc_q, crc_q[7:0]);
    crc_d         = crc_q;
    entry_d.op    = opcode_i;
    entry_d.byte0 = data_byte_i;
    entry_d.byte1 = 8'h00;
    case (opcode_i)
      OP_START: crc_d = '0;
      OP_DATA:  crc_d = crc16_byte(crc_q, data_byte_i);
      OP_CRC: begin
        entry_d.byte0 = crc_q[7:0];
        entry_d.byte1 = crc_q[15:8];
        crc_d         = crc16_byte(crc_lo, crc_q[15:8]);
      end
      OP_END:   crc_d = crc_q;
      default:  crc_d = crc_q;
    endcase
  end

  always_comb begin
    case ({accept, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        crc_q    <= crc_d;
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entries_q[wr_ptr_q] <= entry_d;
    end
  end

  // A start command always leaves the CRC cleared for the frame body.
  a_start_clears_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == OP_START) |=> (crc_q == '0))
    else $error("CRC not cleared by start command");

endmodule

// ----- rtl/bscfe_back.sv -----
// Back end: symbol engine that turns queued commands into line bits, stuffs
// zeros, maps bits to symbols and packs four symbols per result byte.
// Depends on bscfe_pkg.
module bscfe_back import bscfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam logic [1:0] SYM_ONE   = 2'd2;
  localparam logic [1:0] SYM_ZERO  = 2'd3;
  localparam logic [2:0] STUFF_RUN = 3'd5;
  localparam logic [7:0] FLAG_BYTE = 8'h7E;

  typedef struct packed {
    logic [7:0] part;
    logic [1:0] cnt;
    logic [2:0] run;
    logic       emit;
    logic [7:0] data;
  } pack_t;

  function automatic pack_t put_sym(input pack_t s, input logic [1:0] sym);
    pack_t r;
    r      = s;
    r.part = {sym, s.part[7:2]};
    if (s.cnt == 2'd3) begin
      r.emit = 1'b1;
      r.data = r.part;
      r.part = '0;
      r.cnt  = '0;
    end else begin
      r.cnt = s.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic pack_t put_bit(input pack_t s, input logic b, input logic stuff_en);
    pack_t r;
    r     = s;
    r.run = b ? (s.run + 1'b1) : 3'd0;
    r     = put_sym(r, b ? SYM_ONE : SYM_ZERO);
    if (stuff_en && r.run >= STUFF_RUN) begin
      r.run = '0;
      r     = put_sym(r, SYM_ZERO);
    end
    return r;
  endfunction

  logic [7:0] partial_q, partial_d;
  logic [1:0] cnt_q, cnt_d;
  logic [2:0] run_q, run_d;
  logic [2:0] step_q, step_d;
  logic       hold_valid_q, hold_valid_d;
  logic [7:0] hold_data_q, hold_data_d;
  logic       hold_mark_q, hold_mark_d;
  logic       flush_q, flush_d;

  logic       go;
  logic       final_step;
  logic       is_flag;
  logic [7:0] flag_pair;
  logic [7:0] data_src;
  logic [7:0] data_pair;
  logic [7:0] pair;
  logic       nb_valid;
  logic [7:0] nb_data;
  logic       nb_mark;
  pack_t      st;

  assign go = cmd_valid_i && !res_full_i && !flush_q;

  always_comb begin
    case (cmd_i.op)
      OP_START: final_step = (step_q == 3'd3);
      OP_DATA:  final_step = (step_q == 3'd3);
      OP_CRC:   final_step = (step_q == 3'd7);
      OP_END:   final_step = (step_q == 3'd5);
      default:  final_step = 1'b1;
    endcase
  end

  // Each flag or data step handles two line bits, so at most three symbols and one
  // completed byte per cycle; closing end-frame steps pad the byte and add the mark.
  always_comb begin
    st.part = partial_q;
    st.cnt  = cnt_q;
    st.run  = run_q;
    st.emit = 1'b0;
    st.data = '0;
    if (cmd_i.op == OP_START && step_q == '0) begin
      st.part = '0;
      st.cnt  = '0;
      st.run  = '0;
    end
    is_flag   = (cmd_i.op == OP_START) || (cmd_i.op == OP_END && !step_q[2]);
    flag_pair = FLAG_BYTE << {step_q[1:0], 1'b0};
    data_src  = step_q[2] ? cmd_i.byte1 : cmd_i.byte0;
    data_pair = data_src << {step_q[1:0], 1'b0};
    pair      = is_flag ? flag_pair : data_pair;
    nb_valid  = 1'b0;
    nb_data   = '0;
    nb_mark   = 1'b0;
    if (cmd_i.op == OP_END && step_q[2]) begin
      if (step_q[1:0] == 2'd0) begin
        // Pad the open byte with 2'b00 symbol slots.
        nb_valid = (st.cnt != '0);
        case (st.cnt)
          2'd1:    nb_data = st.part >> 6;
          2'd2:    nb_data = st.part >> 4;
          2'd3:    nb_data = st.part >> 2;
          default: nb_data = st.part;
        endcase
        st.part = '0;
        st.cnt  = '0;
      end else begin
        nb_valid = 1'b1;
        nb_mark  = 1'b1;
      end
    end else begin
      st = put_bit(st, pair[7], !is_flag);
      st = put_bit(st, pair[6], !is_flag);
      if (is_flag) begin
        st.run = '0;
      end
      nb_valid = st.emit;
      nb_data  = st.data;
    end
  end

  // The newest byte of a command is held back until it is known whether it
  // is the command's final result.
  always_comb begin
    partial_d    = partial_q;
    cnt_d        = cnt_q;
    run_d        = run_q;
    step_d       = step_q;
    hold_valid_d = hold_valid_q;
    hold_data_d  = hold_data_q;
    hold_mark_d  = hold_mark_q;
    flush_d      = flush_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    res_o        = '0;
    if (flush_q) begin
      if (!res_full_i) begin
        res_push_o   = 1'b1;
        res_o        = '{data: hold_data_q, mark: hold_mark_q, last: 1'b1};
        hold_valid_d = 1'b0;
        flush_d      = 1'b0;
      end
    end else if (go) begin
      partial_d = st.part;
      cnt_d     = st.cnt;
      run_d     = st.run;
      if (nb_valid && hold_valid_q) begin
        res_push_o  = 1'b1;
        res_o       = '{data: hold_data_q, mark: hold_mark_q, last: 1'b0};
        hold_data_d = nb_data;
        hold_mark_d = nb_mark;
        flush_d     = final_step;
      end else if (nb_valid) begin
        if (final_step) begin
          res_push_o = 1'b1;
          res_o      = '{data: nb_data, mark: nb_mark, last: 1'b1};
        end else begin
          hold_valid_d = 1'b1;
          hold_data_d  = nb_data;
          hold_mark_d  = nb_mark;
        end
      end else if (hold_valid_q && final_step) begin
        res_push_o   = 1'b1;
        res_o        = '{data: hold_data_q, mark: hold_mark_q, last: 1'b1};
        hold_valid_d = 1'b0;
      end
      if (final_step) begin
        step_d    = '0;
        cmd_pop_o = 1'b1;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q    <= '0;
      cnt_q        <= '0;
      run_q        <= '0;
      step_q       <= '0;
      hold_valid_q <= 1'b0;
      flush_q      <= 1'b0;
    end else begin
      partial_q    <= partial_d;
      cnt_q        <= cnt_d;
      run_q        <= run_d;
      step_q       <= step_d;
      hold_valid_q <= hold_valid_d;
      flush_q      <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_data_q <= hold_data_d;
    hold_mark_q <= hold_mark_d;
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result beat pushed into a full queue");

  a_hold_empty_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == '0 && !flush_q) |-> !hold_valid_q)
    else $error("held result left over between commands");

  a_flush_has_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> hold_valid_q)
    else $error("flush pending without a held result");

endmodule

// ----- rtl/bscfe_res_queue.sv -----
// Result queue: a short FIFO of encoded bytes that presents the oldest beat
// on the output side.
// Depends on bscfe_pkg.
module bscfe_res_queue import bscfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t head_o
);

  res_t              entries_q [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_AW:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (RES_AW+1)'(RES_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= res_i;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (RES_AW+1)'(RES_DEPTH))
    else $error("result queue count out of range");

endmodule

// ----- rtl/bit_stuffed_crc_frame_encoder.sv -----
// Bit-stuffed CRC frame encoder. With both queues empty, the first byte of a
// command reaches the output only once the engine releases it, because the engine
// holds each completed byte until the next byte or the command's final step.
// The symbol engine handles two line bits a cycle while the result queue is not
// full and no flush is pending. A command's final step that completes a byte while
// another waits is followed by a flush of the newer byte before the next command.
// Reset clears both queues, the CRC, the packing state and the stuffing run.
module bit_stuffed_crc_frame_encoder import bscfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       end_mark_o,
  output logic       last_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res;
  res_t head;

  bscfe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bscfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  bscfe_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  assign out_byte_o = head.data;
  assign end_mark_o = head.mark;
  assign last_o     = head.last;

endmodule
